// ===== rtl/tst_pkg.sv =====
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the timeout slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int MAX_FIRE        = 16;
  localparam int FIRE_W          = $clog2(MAX_FIRE + 1);
  localparam int TICK_W          = 32;
  localparam int DUR_W           = 32;
  localparam int CFG_W           = 10;
  localparam int SID_W           = 8;
  localparam int SLOT_OUT_W      = 4;
  localparam int IN_DATA_W       = 48;
  localparam int OUT_DATA_W      = 40;
  localparam int ENTRY_W         = 1 + DUR_W + TICK_W;
  localparam int DIV_STEPS       = DUR_W;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
  localparam logic [CFG_W-1:0] TICK_LEN_RST = CFG_W'(10);

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_POLL   = 2'd1,
    REQ_SCHED  = 2'd2,
    REQ_CANCEL = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_DONE   = 2'd0,
    KIND_FIRED  = 2'd1,
    KIND_NOFREE = 2'd2,
    KIND_BADID  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCHED_WR,
    S_POLL_RD,
    S_POLL_CMP,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/tst_ram.sv =====
// ----------------------------------------------------------------------------
// tst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/timeout_slot_table_unit.sv =====
// ----------------------------------------------------------------------------
// timeout_slot_table_unit
// Tick counter with a table of one-shot / periodic timeout slots.
// ----------------------------------------------------------------------------
// Flow: tick, cancel and full-table schedule go to the response state, which loads the
//   output register once it is free; schedule runs a 32-step divide, the table write and
//   the response; poll reads and compares each active slot, re-arming fired periodic ones.
// Throughput: one request at a time; a new word is taken as soon as the
//   previous one has loaded its final result into the output register.
// Reset: tick counter zero, every slot inactive, tick length 10 ms; payload RAM not cleared.
`default_nettype none

module timeout_slot_table_unit #(
  parameter int SLOTS = tst_pkg::SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration: tick length in ms
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tst_pkg::CFG_W-1:0]      cfg_data,
  // request stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [31:0] duration_ms, [32] periodic, [40:33] slot_id, [47:41] zero
  input  wire logic [tst_pkg::IN_DATA_W-1:0]  s_tdata,
  // [1:0] req_type
  input  wire logic [1:0]                     s_tuser,
  // result stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [3:0] slot, [35:4] tick_now, [39:36] zero
  output logic [tst_pkg::OUT_DATA_W-1:0]      m_tdata,
  // [1:0] kind
  output logic [1:0]                          m_tuser,
  output logic                                m_tlast
);

  import tst_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = $clog2(SLOTS + 1);

  state_t state, state_next;

  // architectural state held in flops
  logic [TICK_W-1:0]     tick_count;
  logic [CFG_W-1:0]      tick_len;
  logic [SLOTS-1:0]      active;

  // request context
  logic                  req_per;
  logic [SLOT_W-1:0]     sched_slot;
  logic [DUR_W-1:0]      dvd;        // dividend in, quotient out
  logic [CFG_W-1:0]      rem;
  logic [CFG_W-1:0]      divisor;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [IDX_W-1:0]      idx;
  logic [FIRE_W-1:0]     fire_cnt;
  logic                  pend_valid; // a fired slot still waits to be sent
  logic [SLOT_OUT_W-1:0] pend_slot;
  kind_t                 resp_kind;
  logic [SLOT_OUT_W-1:0] resp_slot;

  // output register
  logic [TICK_W-1:0]     out_tick;
  logic [SLOT_OUT_W-1:0] out_slot;
  kind_t                 out_kind;
  logic                  out_last;

  logic                  s_accept;
  logic                  out_free;
  req_t                  req_in;
  logic [SLOT_W-1:0]     idx_s;
  logic                  scan_end;

  // table RAM: {periodic, period, expiry}
  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  mem_re;
  logic [ENTRY_W-1:0]    mem_rdata;

  logic                  rd_isper;
  logic [DUR_W-1:0]      rd_period;
  logic [TICK_W-1:0]     rd_expiry;
  logic                  fire;
  logic                  fire_stall;
  logic [TICK_W-1:0]     rearm;

  logic                  free_found;
  logic [SLOT_W-1:0]     free_slot;

  logic [CFG_W:0]        rem_sh;
  logic                  div_ge;
  logic [CFG_W-1:0]      rem_nx;

  logic                  out_load;
  kind_t                 out_kind_n;
  logic [SLOT_OUT_W-1:0] out_slot_n;
  logic                  out_last_n;

  tst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS),
    .AW    (SLOT_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx_s),
    .rdata (mem_rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign req_in    = req_t'(s_tuser);
  assign idx_s     = idx[SLOT_W-1:0];
  assign scan_end  = (idx == IDX_W'(SLOTS)) || (fire_cnt == FIRE_W'(MAX_FIRE));

  assign rd_isper   = mem_rdata[ENTRY_W-1];
  assign rd_period  = mem_rdata[DUR_W+TICK_W-1:TICK_W];
  assign rd_expiry  = mem_rdata[TICK_W-1:0];
  assign fire       = (rd_expiry <= tick_count);
  assign fire_stall = fire && pend_valid && !out_free;
  assign rearm      = tick_count + rd_period;

  // lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  // one restoring-division step per cycle
  assign rem_sh = {rem, dvd[DUR_W-1]};
  assign div_ge = (rem_sh >= {1'b0, divisor});
  assign rem_nx = div_ge ? CFG_W'(rem_sh - {1'b0, divisor}) : rem_sh[CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    out_kind_n = resp_kind;
    out_slot_n = resp_slot;
    out_last_n = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = sched_slot;
    mem_wdata  = {req_per, dvd, tick_count + dvd};
    mem_re     = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          case (req_in)
            REQ_POLL:  state_next = S_POLL_RD;
            REQ_SCHED: state_next = free_found ? S_DIV : S_RESP;
            default:   state_next = S_RESP;
          endcase
        end
      end
      S_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_SCHED_WR;
        end
      end
      S_SCHED_WR: begin
        mem_we     = 1'b1;
        state_next = S_RESP;
      end
      S_POLL_RD: begin
        if (scan_end) begin
          state_next = S_RESP;
        end else if (active[idx_s]) begin
          mem_re     = 1'b1;
          state_next = S_POLL_CMP;
        end
      end
      S_POLL_CMP: begin
        if (!fire) begin
          state_next = S_POLL_RD;
        end else if (!fire_stall) begin
          // send the previous hit, it is known not to be the last one
          out_load   = pend_valid;
          out_kind_n = KIND_FIRED;
          out_slot_n = pend_slot;
          out_last_n = 1'b0;
          // re-arm a periodic slot; a one-shot slot just drops its active bit
          mem_we     = rd_isper;
          mem_waddr  = idx_s;
          mem_wdata  = {1'b1, rd_period, rearm};
          state_next = S_POLL_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      tick_len    <= TICK_LEN_RST;
      active      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tick_len <= cfg_data;
      end
      if (s_accept && req_in == REQ_TICK) begin
        tick_count <= tick_count + TICK_W'(1);
      end
      if (s_accept && req_in == REQ_CANCEL &&
          s_tdata[40:33] < SID_W'(SLOTS)) begin
        active[s_tdata[32+SLOT_W:33]] <= 1'b0;
      end
      if (state == S_SCHED_WR) begin
        active[sched_slot] <= 1'b1;
      end
      if (state == S_POLL_CMP && fire && !fire_stall && !rd_isper) begin
        active[idx_s] <= 1'b0;
      end
    end
  end

  // request context; every field is loaded before it is used
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          req_per    <= s_tdata[32];
          resp_kind  <= KIND_DONE;
          resp_slot  <= '0;
          idx        <= '0;
          fire_cnt   <= '0;
          pend_valid <= 1'b0;
          sched_slot <= free_slot;
          dvd        <= s_tdata[DUR_W-1:0];
          rem        <= '0;
          div_cnt    <= '0;
          divisor    <= (tick_len == '0) ? CFG_W'(1) : tick_len;
          if (req_in == REQ_CANCEL && s_tdata[40:33] >= SID_W'(SLOTS)) begin
            resp_kind <= KIND_BADID;
          end
          if (req_in == REQ_SCHED && !free_found) begin
            resp_kind <= KIND_NOFREE;
          end
        end
      end
      S_DIV: begin
        rem     <= rem_nx;
        dvd     <= {dvd[DUR_W-2:0], div_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      S_SCHED_WR: begin
        resp_slot <= SLOT_OUT_W'(sched_slot);
      end
      S_POLL_RD: begin
        if (scan_end) begin
          resp_kind <= pend_valid ? KIND_FIRED : KIND_DONE;
          resp_slot <= pend_valid ? pend_slot : '0;
        end else if (!active[idx_s]) begin
          idx <= idx + IDX_W'(1);
        end
      end
      S_POLL_CMP: begin
        if (!fire) begin
          idx <= idx + IDX_W'(1);
        end else if (!fire_stall) begin
          pend_valid <= 1'b1;
          pend_slot  <= SLOT_OUT_W'(idx_s);
          fire_cnt   <= fire_cnt + FIRE_W'(1);
          idx        <= idx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind <= out_kind_n;
      out_slot <= out_slot_n;
      out_last <= out_last_n;
      out_tick <= tick_count;
    end
  end

  assign m_tdata = {(OUT_DATA_W - TICK_W - SLOT_OUT_W)'(0), out_tick, out_slot};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  // the state has left idle in the cycle after every accepted word
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> state != S_IDLE)
    else $error("accepted word did not start work");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !out_load)
    else $error("output register overwritten");

  // schedule only writes into a slot that was free
  a_sched_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCHED_WR) |-> !active[sched_slot])
    else $error("schedule into active slot");

  // the scan stops once the fire limit is reached
  a_fire_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_POLL_CMP) |-> (fire_cnt < FIRE_W'(MAX_FIRE)))
    else $error("fire limit exceeded");

endmodule

`default_nettype wire

// ===== dv/timeout_slot_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// timeout_slot_table_unit_test
// Self-checking bench for the timeout slot table. Requests go in on the slave
// stream with random gaps, and results are drained with random back-pressure,
// including one long hold-off that fills the block and stalls its input. A
// shadow copy of the tick counter and slot table predicts every result word,
// and each word is compared field by field in arrival order. The run walks
// through several tick-length settings, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module timeout_slot_table_unit_test;
  import tst_pkg::*;

  // One predicted result word.
  typedef struct {
    kind_t       kind;
    logic [3:0]  slot;
    logic [31:0] tick_now;
    logic        last;
  } timer_result_t;

  // Shadow of the tick counter and slot table; holds the result words that
  // are still owed by the block.
  class timeout_table_tracker;
    logic [CFG_W-1:0]  tick_len;
    logic [TICK_W-1:0] tick_count;
    bit                armed      [SLOTS_DEF];
    bit                repeating  [SLOTS_DEF];
    logic [31:0]       period     [SLOTS_DEF];
    logic [31:0]       expiry     [SLOTS_DEF];
    timer_result_t     owed_results[$];
    int                errors;

    function new();
      tick_len    = TICK_LEN_RST;
      tick_count  = '0;
      errors      = 0;
      foreach (armed[i]) begin
        armed[i]     = 1'b0;
        repeating[i] = 1'b0;
        period[i]    = '0;
        expiry[i]    = '0;
      end
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    function void set_divisor(logic [CFG_W-1:0] value);
      tick_len = value;
    endfunction

    function void owe(kind_t kind, int slot, logic last);
      timer_result_t r;
      r.kind     = kind;
      r.slot     = slot[3:0];
      r.tick_now = tick_count;
      r.last     = last;
      owed_results.push_back(r);
    endfunction

    // Apply one accepted request word to the shadow and queue its results.
    function void note_request(req_t req, logic [31:0] dur, logic per, logic [7:0] sid);
      logic [31:0]   div;
      int            fired;
      timer_result_t tail;
      case (req)
        REQ_TICK: begin
          tick_count = tick_count + 1;
          owe(KIND_DONE, 0, 1'b1);
        end
        REQ_POLL: begin
          fired = 0;
          for (int i = 0; i < SLOTS_DEF && fired < MAX_FIRE; i++) begin
            if (armed[i] && expiry[i] <= tick_count) begin
              owe(KIND_FIRED, i, 1'b0);
              fired++;
              if (repeating[i]) expiry[i] = tick_count + period[i];
              else armed[i] = 1'b0;
            end
          end
          if (fired == 0) begin
            owe(KIND_DONE, 0, 1'b1);
          end else begin
            // mark the final fire word of this poll
            tail = owed_results.pop_back();
            tail.last = 1'b1;
            owed_results.push_back(tail);
          end
        end
        REQ_SCHED: begin
          div = (tick_len == 0) ? 32'd1 : 32'(tick_len);
          fired = -1;
          for (int i = 0; i < SLOTS_DEF && fired < 0; i++)
            if (!armed[i]) fired = i;
          if (fired < 0) begin
            owe(KIND_NOFREE, 0, 1'b1);
          end else begin
            period[fired]    = dur / div;
            expiry[fired]    = tick_count + period[fired];
            repeating[fired] = per;
            armed[fired]     = 1'b1;
            owe(KIND_DONE, fired, 1'b1);
          end
        end
        default: begin
          if (sid < SLOTS_DEF) begin
            armed[sid] = 1'b0;
            owe(KIND_DONE, 0, 1'b1);
          end else begin
            owe(KIND_BADID, 0, 1'b1);
          end
        end
      endcase
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    endfunction

    // Compare one drained result word with the oldest owed one.
    function void check_result(logic [1:0] kind, logic [3:0] slot, logic [31:0] tick_now,
                               logic last);
      timer_result_t want;
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0h slot %0h tick %0h last %0b",
                 $time, kind, slot, tick_now, last);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (kind !== want.kind)         report("kind", want.kind, kind);
      if (slot !== want.slot)         report("slot", want.slot, slot);
      if (tick_now !== want.tick_now) report("tick_now", want.tick_now, tick_now);
      if (last !== want.last)         report("last", want.last, last);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_W-1:0]      cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [31:0] duration_ms, [32] periodic, [40:33] slot_id
  logic [1:0]            s_tuser;   // [1:0] req_type
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // [3:0] slot, [35:4] tick_now
  logic [1:0]            m_tuser;   // [1:0] kind
  logic                  m_tlast;

  timeout_table_tracker tracker;
  int                   results_seen;
  bit                   sender_gaps;

  timeout_slot_table_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Drain side: check every word taken at a rising edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_result(m_tuser, m_tdata[3:0], m_tdata[35:4], m_tlast);
      results_seen++;
    end
  end

  // Back-pressure on the result stream: random stalls, calm stretches with
  // none, and one long hold-off that backs the block up into its input.
  initial begin : result_ready_driver
    int stall_left;
    int calm_left;
    bit held_off;
    m_tready   = 1'b0;
    stall_left = 0;
    calm_left  = 0;
    held_off   = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= 80) begin
        held_off   = 1'b1;
        stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 150);
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Offer one request word, starting and ending at a falling edge. Valid is
  // left high on return so back-to-back words never drop it within a step.
  task automatic send_request(input req_t req, input logic [31:0] dur, input logic per,
                              input logic [7:0] sid);
    int gap;
    gap = sender_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, sid, per, dur};
    s_tuser  <= req;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_request(req, dur, per, sid);
    @(negedge clk);
  endtask

  // Drop valid, let the block drain, then write the tick length.
  task automatic write_divisor(input logic [CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    tracker.set_divisor(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random request, or a run of ticks closed by a poll. Returns the
  // number of words sent.
  task automatic send_random(output int count);
    int          r;
    int          div;
    int          burst;
    logic [31:0] dur;
    logic [7:0]  sid;
    r     = $urandom_range(0, 99);
    div   = (tracker.tick_len == 0) ? 1 : int'(tracker.tick_len);
    dur   = $urandom;
    sid   = 8'($urandom_range(0, 255));
    count = 1;
    if (r < 28) begin
      if ($urandom_range(0, 4) == 0) begin
        // advance time a few ticks, then collect what expired
        burst = $urandom_range(2, 6);
        repeat (burst) send_request(REQ_TICK, $urandom, 1'($urandom_range(0, 1)), sid);
        send_request(REQ_POLL, dur, 1'($urandom_range(0, 1)), sid);
        count = burst + 1;
      end else begin
        send_request(REQ_TICK, dur, 1'($urandom_range(0, 1)), sid);
      end
    end else if (r < 50) begin
      send_request(REQ_POLL, dur, 1'($urandom_range(0, 1)), sid);
    end else if (r < 82) begin
      case ($urandom_range(0, 9))
        0:       dur = $urandom;
        1:       dur = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        default: dur = $urandom_range(0, div * 6);
      endcase
      send_request(REQ_SCHED, dur, 1'($urandom_range(0, 1)), sid);
    end else begin
      if ($urandom_range(0, 4) != 0) sid = 8'($urandom_range(0, SLOTS_DEF - 1));
      else sid = 8'($urandom_range(SLOTS_DEF, 255));
      send_request(REQ_CANCEL, dur, 1'($urandom_range(0, 1)), sid);
    end
  endtask

  task automatic run_random(input logic [CFG_W-1:0] divisor, input int n, input bit gaps);
    int sent;
    int count;
    write_divisor(divisor);
    sender_gaps = gaps;
    sent = 0;
    while (sent < n) begin
      send_random(count);
      sent += count;
    end
  endtask

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("timeout_slot_table_unit_test: FAIL");
    $finish;
  end

  initial begin
    tracker      = new();
    results_seen = 0;
    sender_gaps  = 1'b1;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = REQ_TICK;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset divisor of 10.
    send_request(REQ_POLL, 32'h0, 1'b0, 8'h00);           // poll on an empty table
    send_request(REQ_SCHED, 32'hFFFF_FFFF, 1'b0, 8'hFF);  // longest duration, one-shot
    send_request(REQ_SCHED, 32'd9, 1'b1, 8'h00);          // zero period, periodic
    send_request(REQ_POLL, 32'h0, 1'b0, 8'h00);           // zero period fires and re-arms
    send_request(REQ_POLL, 32'h0, 1'b1, 8'h00);           // and fires again
    send_request(REQ_CANCEL, 32'h0, 1'b0, 8'd0);
    send_request(REQ_CANCEL, 32'h0, 1'b0, 8'd1);
    send_request(REQ_CANCEL, 32'h0, 1'b0, 8'd5);          // cancel of an inactive slot
    send_request(REQ_CANCEL, 32'h0, 1'b0, 8'd16);         // first id out of range
    send_request(REQ_CANCEL, 32'h0, 1'b0, 8'd255);        // largest id
    // fill every slot, then one more schedule finds the table full
    for (int i = 0; i < SLOTS_DEF; i++)
      send_request(REQ_SCHED, 32'(i), i[0], 8'hA5);
    send_request(REQ_SCHED, 32'd100, 1'b1, 8'h5A);
    send_request(REQ_TICK, 32'h0, 1'b0, 8'h00);
    send_request(REQ_POLL, 32'h0, 1'b0, 8'h00);           // all sixteen fire at once

    // Random part across divisor settings; one phase with no sender gaps.
    run_random(10'd1, 24, 1'b1);
    run_random(10'd1000, 24, 1'b1);
    run_random(10'd0, 24, 1'b0);
    run_random(10'd1023, 24, 1'b1);
    run_random(10'($urandom_range(2, 999)), 24, 1'b1);
    run_random(10'd10, 24, 1'b1);

    // Drain, then keep watching for stray words.
    s_tvalid <= 1'b0;
    while (tracker.outstanding() > 0) @(negedge clk);
    repeat (80) @(negedge clk);

    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("timeout_slot_table_unit_test: PASS");
    end else begin
      $display("timeout_slot_table_unit_test: FAIL");
    end
    $finish;
  end

endmodule
